// File: rtl/core/spd_pkg.sv
// Package for the sensor packet deframer: phase codes, record and status
// codes, the result record type and the framing constants. No dependencies.
`default_nettype none

package spd_pkg;

  localparam logic [7:0]  HDR_HIGH     = 8'hEF;
  localparam logic [7:0]  HDR_LOW      = 8'h01;
  localparam logic [15:0] ADDR_BYTES   = 16'd4;
  localparam logic [15:0] LEN_OVERHEAD = 16'd2;

  typedef enum logic [3:0] {
    PH_HUNT_HI = 4'd0,
    PH_HUNT_LO = 4'd1,
    PH_ADDR    = 4'd2,
    PH_PID     = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_HI   = 4'd7,
    PH_CK_LO   = 4'd8
  } phase_t;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_END     = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  packet_id;
    logic [31:0] device_address;
    logic [15:0] frame_length;
    logic [1:0]  frame_status;
  } rec_t;

  // Input register contents handed to the deframer core.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  // One result from the core: whether the byte produced a record, and the record.
  typedef struct packed {
    logic valid;
    rec_t rec;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/spd_if.sv
// Channel interfaces of the sensor packet deframer: received bytes in and
// records out, each with valid/ready. Standalone, no package needed.
`default_nettype none

interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  packet_id;
  logic [31:0] device_address;
  logic [15:0] frame_length;
  logic [1:0]  frame_status;

  modport source (output valid, output record_kind, output payload_byte,
                  output payload_index, output packet_id, output device_address,
                  output frame_length, output frame_status, input ready);
  modport sink   (input valid, input record_kind, input payload_byte,
                  input payload_index, input packet_id, input device_address,
                  input frame_length, input frame_status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spd_in_stage.sv
// Input register of the deframer: takes one received byte per request.
// Depends on spd_pkg (stage_t) and spd_if (spd_byte_if).
`default_nettype none

module spd_in_stage
  import spd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  spd_byte_if.sink    bytes,
  input  wire logic   step,
  output stage_t      stage
);

  // Accept when empty or when the held byte moves on this cycle.
  assign bytes.ready = !stage.valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (bytes.ready) begin
      stage.valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      stage.data <= bytes.rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spd_core.sv
// Deframer core: phase machine, held frame fields and running checksum.
// Depends on spd_pkg.
`default_nettype none

module spd_core
  import spd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_data,
  output res_t            res
);

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] held_address, held_address_next;
  logic [7:0]  held_packet_id, held_packet_id_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  checksum_high, checksum_high_next;

  logic [15:0] count_inc;
  logic [15:0] len_low;
  logic [15:0] payload_len;

  assign count_inc   = byte_count + 16'd1;
  assign len_low     = {held_length[15:8], rx_data};
  assign payload_len = held_length - LEN_OVERHEAD;

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT_HI: if (rx_data == HDR_HIGH) phase_next = PH_HUNT_LO;
      PH_HUNT_LO: begin
        if (rx_data == HDR_LOW) begin
          phase_next = PH_ADDR;
        end else if (rx_data != HDR_HIGH) begin
          phase_next = PH_HUNT_HI;
        end
      end
      PH_ADDR:    if (count_inc >= ADDR_BYTES) phase_next = PH_PID;
      PH_PID:     phase_next = PH_LEN_HI;
      PH_LEN_HI:  phase_next = PH_LEN_LO;
      PH_LEN_LO: begin
        if (len_low < LEN_OVERHEAD) begin
          phase_next = PH_HUNT_HI;
        end else if (len_low == LEN_OVERHEAD) begin
          phase_next = PH_CK_HI;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: if (count_inc >= payload_len) phase_next = PH_CK_HI;
      PH_CK_HI:   phase_next = PH_CK_LO;
      PH_CK_LO:   phase_next = PH_HUNT_HI;
      default:    phase_next = PH_HUNT_HI;
    endcase
  end

  // Held fields, running sum and the record for this byte.
  always_comb begin
    byte_count_next     = byte_count;
    held_address_next   = held_address;
    held_packet_id_next = held_packet_id;
    held_length_next    = held_length;
    running_sum_next    = running_sum;
    checksum_high_next  = checksum_high;

    res.valid              = 1'b0;
    res.rec.record_kind    = KIND_PAYLOAD;
    res.rec.payload_byte   = 8'd0;
    res.rec.payload_index  = 16'd0;
    res.rec.packet_id      = held_packet_id;
    res.rec.device_address = held_address;
    res.rec.frame_length   = held_length;
    res.rec.frame_status   = ST_OK;

    unique case (phase)
      PH_HUNT_HI: ;
      PH_HUNT_LO: begin
        if (rx_data == HDR_LOW) begin
          byte_count_next   = 16'd0;
          held_address_next = 32'd0;
        end
      end
      PH_ADDR: begin
        held_address_next = {held_address[23:0], rx_data};
        byte_count_next   = count_inc;
      end
      PH_PID: begin
        held_packet_id_next = rx_data;
        running_sum_next    = {8'd0, rx_data};
      end
      PH_LEN_HI: begin
        held_length_next = {rx_data, 8'd0};
        running_sum_next = running_sum + {8'd0, rx_data};
      end
      PH_LEN_LO: begin
        held_length_next = len_low;
        running_sum_next = running_sum + {8'd0, rx_data};
        byte_count_next  = 16'd0;
        if (len_low < LEN_OVERHEAD) begin
          res.valid            = 1'b1;
          res.rec.record_kind  = KIND_END;
          res.rec.frame_length = len_low;
          res.rec.frame_status = ST_SHORT;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next      = running_sum + {8'd0, rx_data};
        byte_count_next       = count_inc;
        res.valid             = 1'b1;
        res.rec.payload_byte  = rx_data;
        res.rec.payload_index = byte_count;
      end
      PH_CK_HI: checksum_high_next = rx_data;
      PH_CK_LO: begin
        res.valid            = 1'b1;
        res.rec.record_kind  = KIND_END;
        res.rec.frame_status = ({checksum_high, rx_data} == running_sum) ? ST_OK : ST_BAD_SUM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT_HI;
      byte_count     <= 16'd0;
      held_address   <= 32'd0;
      held_packet_id <= 8'd0;
      held_length    <= 16'd0;
      running_sum    <= 16'd0;
      checksum_high  <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      held_address   <= held_address_next;
      held_packet_id <= held_packet_id_next;
      held_length    <= held_length_next;
      running_sum    <= running_sum_next;
      checksum_high  <= checksum_high_next;
    end
  end

  // Records come only from the length, payload and checksum phases.
  a_res_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (phase == PH_LEN_LO || phase == PH_PAYLOAD || phase == PH_CK_LO))
    else $error("record produced outside a record phase");

  // Payload indexes stay inside the announced payload.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (byte_count < payload_len))
    else $error("payload index beyond frame length");

  // A short-length report always carries a length below two.
  a_short_len: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.rec.frame_status == ST_SHORT) |-> (res.rec.frame_length < LEN_OVERHEAD))
    else $error("short status with a valid length");

  // Leaving the checksum low phase always returns to the hunt.
  a_ck_return: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_CK_LO) |=> (phase == PH_HUNT_HI))
    else $error("frame end did not restart the hunt");

endmodule

`default_nettype wire

// File: rtl/core/spd_out_reg.sv
// Result register of the deframer: holds one record until it is taken.
// Depends on spd_pkg (res_t) and spd_if (spd_rec_if).
`default_nettype none

module spd_out_reg
  import spd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  res_t      res,
  output logic      free,
  spd_rec_if.source records
);

  // Free when empty or when the held record is taken this cycle.
  assign free = !records.valid || records.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (step) begin
      records.valid <= res.valid;
    end else if (records.ready) begin
      records.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      records.record_kind    <= res.rec.record_kind;
      records.payload_byte   <= res.rec.payload_byte;
      records.payload_index  <= res.rec.payload_index;
      records.packet_id      <= res.rec.packet_id;
      records.device_address <= res.rec.device_address;
      records.frame_length   <= res.rec.frame_length;
      records.frame_status   <= res.rec.frame_status;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sensor_packet_deframer.sv
// Sensor packet deframer top level: input register, deframer core, result register.
// A byte is held in the input register and its record in the result register.
// Throughput: one byte per cycle while the result register is free; the sum is 16-bit.
// No byte moves while a record waits; only a held record that is not taken
// stalls the input. Reset (rst, synchronous) empties both registers and
// returns the core to the header hunt with all held fields cleared.
// Depends on spd_pkg, spd_if, spd_in_stage, spd_core and spd_out_reg.
`default_nettype none

module sensor_packet_deframer
  import spd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  spd_byte_if.sink  bytes,
  spd_rec_if.source records
);

  stage_t stage;
  res_t   res;
  logic   free;
  logic   step;

  // Advance the held byte when the result register can take its outcome.
  // A byte that causes no record still waits for a free result register.
  assign step = stage.valid && free;

  spd_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .step  (step),
    .stage (stage)
  );

  // Phase machine and frame fields; records come out combinationally per byte.
  spd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_data (stage.data),
    .res     (res)
  );

  // Hold each record until the downstream request completes.
  spd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .res     (res),
    .free    (free),
    .records (records)
  );

endmodule

`default_nettype wire

// File: test/sensor_packet_deframer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_packet_deframer: drives received bytes,
// predicts payload and end-of-frame records, and checks every record taken.
// Depends on spd_pkg, spd_if and the sensor_packet_deframer RTL.

module sensor_packet_deframer_test;
  import spd_pkg::*;

  // A run of this many cycles with no request on either side means a hang.
  localparam int QUIET_LIMIT = 2000;
  // Extra cycles allowed after the last owed record before calling the run done.
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 225;

  // One stimulus row: the byte, and optionally a hand-written record that
  // the byte must produce (used instead of the predictor for that row).
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    rec_t       want;
  } stim_t;

  localparam int DIR_ROWS = 24;
  localparam stim_t DIRECTED [DIR_ROWS] = '{
    // Noise is ignored, then a header high byte followed by junk restarts the hunt.
    '{8'h00, 1'b0, '0},
    '{8'hEF, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    // A repeated high byte keeps the hunt waiting for the low byte.
    '{8'hEF, 1'b0, '0},
    '{8'hEF, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    // All-ones address, zero identifier, zero length: short frame reported at once.
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1,
      '{KIND_END, 8'h00, 16'h0000, 8'h00, 32'hFFFF_FFFF, 16'h0000, ST_SHORT}},
    // Zero address, identifier FF, length two: checksum follows directly,
    // and 0x0100 differs from the true sum 0x0101.
    '{8'hEF, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b1,
      '{KIND_END, 8'h00, 16'h0000, 8'hFF, 32'h0000_0000, 16'h0002, ST_BAD_SUM}}
  };

  logic clk;
  logic rst;

  spd_byte_if byte_ch ();
  spd_rec_if  rec_ch ();

  sensor_packet_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .records (rec_ch)
  );

  // Bytes waiting to be offered, the one on the wire, and the records owed.
  stim_t      byte_q [$];
  stim_t      on_wire;
  rec_t       owed_records [$];
  logic [7:0] last_pushed;
  int         pushed;
  int         errors;
  int         quiet;
  int         send_idle_pct;
  int         recv_stall_pct;

  // Deframer shadow state.
  phase_t      df_phase;
  logic [15:0] df_count;
  logic [31:0] df_addr;
  logic [7:0]  df_pid;
  logic [15:0] df_len;
  logic [15:0] df_sum;
  logic [7:0]  df_ck_hi;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    rec_ch.ready    = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic deframe_reset();
    df_phase = PH_HUNT_HI;
    df_count = '0;
    df_addr  = '0;
    df_pid   = '0;
    df_len   = '0;
    df_sum   = '0;
    df_ck_hi = '0;
  endtask

  // Advance the shadow deframer by one byte; emit says whether a record comes out.
  task automatic deframe_byte(input logic [7:0] b, output bit emit, output rec_t r);
    logic [15:0] rx_sum;
    emit = 1'b0;
    r = '0;
    case (df_phase)
      PH_HUNT_HI: begin
        if (b == HDR_HIGH) df_phase = PH_HUNT_LO;
      end
      PH_HUNT_LO: begin
        if (b == HDR_LOW) begin
          df_phase = PH_ADDR;
          df_count = '0;
          df_addr  = '0;
        end else if (b != HDR_HIGH) begin
          df_phase = PH_HUNT_HI;
        end
      end
      PH_ADDR: begin
        df_addr  = {df_addr[23:0], b};
        df_count = df_count + 16'd1;
        if (df_count >= ADDR_BYTES) df_phase = PH_PID;
      end
      PH_PID: begin
        df_pid   = b;
        df_sum   = {8'h00, b};
        df_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        df_len   = {b, 8'h00};
        df_sum   = df_sum + {8'h00, b};
        df_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        df_len   = {df_len[15:8], b};
        df_sum   = df_sum + {8'h00, b};
        df_count = '0;
        if (df_len < LEN_OVERHEAD) begin
          df_phase = PH_HUNT_HI;
          emit = 1'b1;
          r = '{KIND_END, 8'h00, 16'h0000, df_pid, df_addr, df_len, ST_SHORT};
        end else begin
          df_phase = (df_len == LEN_OVERHEAD) ? PH_CK_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        df_sum = df_sum + {8'h00, b};
        emit = 1'b1;
        r = '{KIND_PAYLOAD, b, df_count, df_pid, df_addr, df_len, ST_OK};
        df_count = df_count + 16'd1;
        if (df_count >= df_len - LEN_OVERHEAD) df_phase = PH_CK_HI;
      end
      PH_CK_HI: begin
        df_ck_hi = b;
        df_phase = PH_CK_LO;
      end
      PH_CK_LO: begin
        rx_sum   = {df_ck_hi, b};
        df_phase = PH_HUNT_HI;
        emit = 1'b1;
        r = '{KIND_END, 8'h00, 16'h0000, df_pid, df_addr, df_len,
              (rx_sum == df_sum) ? ST_OK : ST_BAD_SUM};
      end
      default: df_phase = PH_HUNT_HI;
    endcase
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_record(input rec_t got, input rec_t want);
    if (got.record_kind !== want.record_kind)
      log_mismatch("record_kind", 32'(got.record_kind), 32'(want.record_kind));
    if (got.payload_byte !== want.payload_byte)
      log_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    if (got.payload_index !== want.payload_index)
      log_mismatch("payload_index", 32'(got.payload_index), 32'(want.payload_index));
    if (got.packet_id !== want.packet_id)
      log_mismatch("packet_id", 32'(got.packet_id), 32'(want.packet_id));
    if (got.device_address !== want.device_address)
      log_mismatch("device_address", got.device_address, want.device_address);
    if (got.frame_length !== want.frame_length)
      log_mismatch("frame_length", 32'(got.frame_length), 32'(want.frame_length));
    if (got.frame_status !== want.frame_status)
      log_mismatch("frame_status", 32'(got.frame_status), 32'(want.frame_status));
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back('{b, 1'b0, '0});
    last_pushed = b;
    pushed++;
  endtask

  // Random junk; never let it form a header, or a frame of random length
  // would swallow the stream.
  task automatic push_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (last_pushed == HDR_HIGH && b == HDR_LOW) b = 8'h00;
      push_byte(b);
    end
  endtask

  // Push one complete frame with a correct checksum, or a spoiled one.
  task automatic push_frame(input logic [15:0] len, input bit spoil);
    logic [15:0] sum;
    logic [7:0]  pid;
    logic [7:0]  pb;
    push_byte(HDR_HIGH);
    push_byte(HDR_LOW);
    repeat (4) push_byte(8'($urandom));
    pid = 8'($urandom);
    push_byte(pid);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    sum = {8'h00, pid} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
    if (len >= LEN_OVERHEAD) begin
      for (int i = 0; i < int'(len - LEN_OVERHEAD); i++) begin
        pb = 8'($urandom);
        sum = sum + {8'h00, pb};
        push_byte(pb);
      end
      if (spoil) sum = sum ^ 16'($urandom_range(1, 65535));
      push_byte(sum[15:8]);
      push_byte(sum[7:0]);
    end
  endtask

  // Mostly well-formed frames of small length, with junk and broken headers mixed in.
  task automatic push_random_phase();
    int          pick;
    int          len_pick;
    logic [15:0] len;
    logic [7:0]  b;
    pushed = 0;
    while (pushed < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        len_pick = $urandom_range(9);
        if (len_pick == 0) len = 16'($urandom_range(1));
        else if (len_pick == 1) len = LEN_OVERHEAD;
        else len = 16'($urandom_range(3, 12));
        push_frame(len, $urandom_range(99) < 20);
      end else if (pick < 88) begin
        push_noise($urandom_range(1, 4));
      end else begin
        // Header high byte, then anything but the low byte.
        push_byte(HDR_HIGH);
        b = 8'($urandom);
        if (b == HDR_LOW) b = 8'h02;
        push_byte(b);
      end
    end
  endtask

  // All handshake activity lives in one block so that checking, prediction
  // and driving see the values from before this edge.
  always @(posedge clk) begin : lanes
    rec_t got_rec;
    rec_t pred;
    bit   emit;
    bit   busy;
    if (rst) begin
      byte_ch.valid <= 1'b0;
      rec_ch.ready  <= 1'b0;
      quiet         <= 0;
    end else begin
      busy = 1'b0;

      // Check the record taken at this edge against the oldest one owed.
      if (rec_ch.valid && rec_ch.ready) begin
        busy = 1'b1;
        got_rec = '{rec_ch.record_kind, rec_ch.payload_byte, rec_ch.payload_index,
                    rec_ch.packet_id, rec_ch.device_address, rec_ch.frame_length,
                    rec_ch.frame_status};
        if (owed_records.size() == 0) log_mismatch("unexpected record", 32'd0, 32'd0);
        else check_record(got_rec, owed_records.pop_front());
      end

      // Predict from the byte request accepted at this edge.
      if (byte_ch.valid && byte_ch.ready) begin
        busy = 1'b1;
        deframe_byte(on_wire.b, emit, pred);
        if (on_wire.typed) owed_records.push_back(on_wire.want);
        else if (emit) owed_records.push_back(pred);
      end

      quiet <= busy ? 0 : quiet + 1;

      // Offer the next byte once the current request is gone; hold it otherwise.
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = byte_q.pop_front();
          byte_ch.valid   <= 1'b1;
          byte_ch.rx_byte <= on_wire.b;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end

      rec_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : run
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 78, 0, 13};
    recv_pct = '{0, 0, 78, 13};
    errors = 0;
    quiet = 0;
    last_pushed = 8'h00;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    deframe_reset();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) byte_q.push_back(DIRECTED[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      push_random_phase();
      while (byte_q.size() != 0 || byte_ch.valid) @(posedge clk);
    end

    // Open a frame of the largest length and send a few payload bytes, so that
    // every length bit shows up in the records; the frame is left unfinished.
    push_byte(HDR_HIGH);
    push_byte(HDR_LOW);
    repeat (5) push_byte(8'($urandom));
    push_byte(8'hFF);
    push_byte(8'hFF);
    repeat (16) push_byte(8'($urandom));
    while (byte_q.size() != 0 || byte_ch.valid) @(posedge clk);

    while (owed_records.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_records.size() != 0) log_mismatch("records never produced",
                                               owed_records.size(), 32'd0);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/spd_pkg.sv
rtl/core/spd_if.sv
rtl/core/spd_in_stage.sv
rtl/core/spd_core.sv
rtl/core/spd_out_reg.sv
rtl/core/sensor_packet_deframer.sv
test/sensor_packet_deframer_test.sv
